### hdl/mexp_pkg.sv
// Package for the modular exponentiator.
// Word width, word type, configuration register indexes and mode codes.
// No dependencies.
`default_nettype none

package mexp_pkg;

  localparam int WORD_BITS = 16;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int CFG_IDX_BITS = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_MODULUS          = CFG_IDX_BITS'(0);
  localparam cfg_idx_t CFG_PUBLIC_EXPONENT  = CFG_IDX_BITS'(1);
  localparam cfg_idx_t CFG_PRIVATE_EXPONENT = CFG_IDX_BITS'(2);

  // mode codes
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // reset values of the configuration registers
  localparam word_t MODULUS_RESET  = WORD_BITS'(2);
  localparam word_t EXPONENT_RESET = WORD_BITS'(1);

endpackage

`default_nettype wire

### hdl/mexp_modmul.sv
// Shared modular multiplier: p = a * b mod n, one bit of b per cycle
// (interleaved shift-add with two conditional subtractions per step).
// Depends on mexp_pkg.
`default_nettype none

module mexp_modmul import mexp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire word_t a,
  input  wire word_t b,
  input  wire word_t n,
  output logic       busy,
  output logic       done,
  output word_t      p
);

  word_t                 a_r;
  word_t                 b_r;
  word_t                 n_r;
  word_t                 acc;
  logic [CNT_BITS-1:0]   cnt;

  logic [WORD_BITS:0] dbl;
  word_t              red1;
  logic [WORD_BITS:0] sum;
  word_t              acc_next;

  // acc < n and a < n on entry, so each partial stays below 2n before its subtraction
  always_comb begin
    dbl  = {acc, 1'b0};
    red1 = (dbl >= {1'b0, n_r}) ? WORD_BITS'(dbl - {1'b0, n_r}) : dbl[WORD_BITS-1:0];
    sum  = {1'b0, red1} + (b_r[WORD_BITS-1] ? {1'b0, a_r} : '0);
    acc_next = (sum >= {1'b0, n_r}) ? WORD_BITS'(sum - {1'b0, n_r}) : sum[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_r <= a;
      b_r <= b;
      n_r <= n;
      acc <= '0;
      cnt <= CNT_BITS'(WORD_BITS - 1);
    end else if (busy) begin
      acc <= acc_next;
      b_r <= {b_r[WORD_BITS-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign p = acc;

  a_acc_below_n: assert property (@(posedge clk) disable iff (rst)
    busy && !$past(start && !busy) |-> acc < n_r)
    else $error("modmul partial result not reduced");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("modmul done without a running operation");

endmodule

`default_nettype wire

### hdl/modular_exponentiator.sv
// Modular exponentiator, right-to-left square and multiply on one shared
// modular multiplier. Depends on mexp_pkg and mexp_modmul.
//
// Sequence: an item costs one multiply to reduce the base. Then, for each
//   exponent bit up to the highest set one, it costs a pass through the step
//   state, a square and, for set bits, a multiply. The square after the top
//   bit is skipped. A finish state then loads the output register. An
//   exponent of zero goes from the step state straight to finish, and a
//   modulus below two goes straight to finish with no multiply.
// Throughput: one item at a time; in_stall is high from acceptance until
//   the result is loaded into the output register, which waits while the
//   output is stalled. The next item is taken once the sequencer is back
//   in idle.
// Reset: rst (synchronous) sets modulus to 2, both exponents to 1, and
//   clears the sequencer and out_valid; result and last_out are not reset.
`default_nettype none

module modular_exponentiator import mexp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  // configuration write port
  input  wire logic     cfg_write,
  input  wire cfg_idx_t cfg_index,
  input  wire word_t    cfg_data,
  // input items
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     mode,
  input  wire word_t    value,
  input  wire logic     last_in,
  // result items
  output logic          out_valid,
  input  wire logic     out_stall,
  output word_t         result,
  output logic          last_out
);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;  // base = value mod n
  localparam logic [2:0] ST_STEP   = 3'd2;  // look at next exponent bit
  localparam logic [2:0] ST_MUL    = 3'd3;  // acc = acc * base mod n
  localparam logic [2:0] ST_SQR    = 3'd4;  // base = base * base mod n
  localparam logic [2:0] ST_FINISH = 3'd5;  // hand acc to output register

  // configuration registers
  word_t modulus;
  word_t public_exponent;
  word_t private_exponent;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= MODULUS_RESET;
      public_exponent  <= EXPONENT_RESET;
      private_exponent <= EXPONENT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODULUS:          modulus          <= cfg_data;
        CFG_PUBLIC_EXPONENT:  public_exponent  <= cfg_data;
        CFG_PRIVATE_EXPONENT: private_exponent <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // working registers
  logic [2:0] state;
  word_t      acc;
  word_t      base;
  word_t      expo;
  logic       last_r;

  // shared multiplier command, registered
  logic  mm_start;
  word_t mm_a;
  word_t mm_b;
  logic  mm_busy;
  logic  mm_done;
  word_t mm_p;

  mexp_modmul u_modmul (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .n     (modulus),
    .busy  (mm_busy),
    .done  (mm_done),
    .p     (mm_p)
  );

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mm_start  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // multiplier launches: value * 1 mod n reduces the base on acceptance,
      // then one per exponent step and a square after a non-final multiply
      mm_start <= ((state == ST_IDLE) && in_valid && (modulus >= WORD_BITS'(2))) ||
                  ((state == ST_STEP) && (expo != '0)) ||
                  ((state == ST_MUL) && mm_done && (expo[WORD_BITS-1:1] != '0));
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (modulus < WORD_BITS'(2)) begin
              // degenerate modulus: answer is 0 for every exponent
              state <= ST_FINISH;
            end else begin
              state <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mm_done) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (expo == '0) begin
            state <= ST_FINISH;
          end else begin
            state <= expo[0] ? ST_MUL : ST_SQR;
          end
        end
        ST_MUL: begin
          if (mm_done) begin
            if (expo[WORD_BITS-1:1] == '0) begin
              state <= ST_FINISH;  // no higher bits: skip the last square
            end else begin
              state <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          if (mm_done) begin
            state <= ST_STEP;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          expo   <= (mode == MODE_DECRYPT) ? private_exponent : public_exponent;
          last_r <= last_in;
          acc    <= (modulus < WORD_BITS'(2)) ? '0 : WORD_BITS'(1);
          mm_a   <= WORD_BITS'(1);
          mm_b   <= value;
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          base <= mm_p;
        end
      end
      ST_STEP: begin
        // multiply when the bit is set, else square
        mm_a <= expo[0] ? acc : base;
        mm_b <= base;
      end
      ST_MUL: begin
        if (mm_done) begin
          acc  <= mm_p;
          mm_a <= base;
          mm_b <= base;
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          base <= mm_p;
          expo <= expo >> 1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          result   <= acc;
          last_out <= last_r;
        end
      end
      default: ;
    endcase
  end

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ((modulus < WORD_BITS'(2)) && (result == '0)) ||
                         (result < modulus))
    else $error("result not reduced modulo modulus");

  a_mm_done_in_op: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == ST_REDUCE) || (state == ST_MUL) || (state == ST_SQR))
    else $error("multiplier finished outside an operation state");

  a_step_operands: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (acc < modulus) && (base < modulus) && !mm_busy)
    else $error("operands out of range at exponent step");

endmodule

`default_nettype wire
